// File: sv/plyi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plyi_pkg
// Types, widths and breakpoint/yield ROM contents for the piecewise-linear
// yield interpolator.
// ----------------------------------------------------------------------------
package plyi_pkg;

  localparam int TABLE_POINTS = 32;
  localparam int FRAC_BITS    = 10;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  localparam int MASS_W = 20;
  localparam int TOT_W  = 16;
  localparam int MET_W  = 14;
  localparam int WND_W  = 17;

  localparam int LANES       = 3;
  localparam int LANE_TOTAL  = 0;
  localparam int LANE_METALS = 1;
  localparam int LANE_WIND   = 2;

  localparam int BP_W   = 7;
  localparam int Y_W    = 27;
  localparam int DY_W   = Y_W + 1;
  localparam int DX_W   = 5;
  localparam int T_W    = DX_W + FRAC_BITS;
  localparam int P1_W   = Y_W + DX_W;
  localparam int P2_W   = DY_W + T_W + 1;
  localparam int N_W    = P1_W + FRAC_BITS;
  localparam int DEN_W  = 25;
  localparam int Q_W    = 17;

  localparam int MICRO         = 1000000;
  localparam int HALF_MICRO    = MICRO / 2;
  localparam int BYPASS_OFFSET = 3 << (FRAC_BITS - 1);
  localparam int TOT_MAX       = (1 << (TOT_W - 1)) - 1;
  localparam int MET_MAX       = (1 << MET_W) - 1;

  typedef logic [Y_W-1:0] yval_t;

  typedef struct packed {
    logic                    below;
    logic signed [TOT_W-1:0] bypass;
  } side_t;

  localparam logic [BP_W-1:0] BP_MASS [TABLE_POINTS] = '{
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27,
    7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd35, 7'd40,
    7'd45, 7'd50, 7'd55, 7'd60, 7'd70, 7'd80, 7'd100, 7'd120
  };

  // Yields in units of 1e-6 solar masses
  localparam yval_t YIELD_TAB [LANES][TABLE_POINTS] = '{
    '{
      27'd9389336,  27'd10244748, 27'd10973754, 27'd11837161,
      27'd12628000, 27'd13283933, 27'd13973949, 27'd14867287,
      27'd15229942, 27'd15757695, 27'd15604063, 27'd16343219,
      27'd16144743, 27'd15389504, 27'd14995688, 27'd15197527,
      27'd15178074, 27'd14443274, 27'd14193992, 27'd14117690,
      27'd13952423, 27'd13509647, 27'd13313397, 27'd13354588,
      27'd15109093, 27'd10222817, 27'd8271961,  27'd5883033,
      27'd4969768,  27'd4579023,  27'd4227612,  27'd4386078
    },
    '{
      27'd712336,   27'd520048,   27'd740254,   27'd1026461,
      27'd1282800,  27'd1549433,  27'd1724449,  27'd2314587,
      27'd2590042,  27'd2916695,  27'd3095063,  27'd3709219,
      27'd3934743,  27'd3864504,  27'd4228688,  27'd4699527,
      27'd5152074,  27'd5776274,  27'd6193992,  27'd6813690,
      27'd7216423,  27'd7386647,  27'd8174397,  27'd9856588,
      27'd11739093, 27'd10172817, 27'd8211961,  27'd5813033,
      27'd4829768,  27'd4409023,  27'd4037612,  27'd4216078
    },
    '{
      27'd1086375,  27'd1238961,  27'd1486873,  27'd1632861,
      27'd1816102,  27'd2085835,  27'd2258426,  27'd2599328,
      27'd3188975,  27'd3616268,  27'd4586832,  27'd5144166,
      27'd6223336,  27'd7510593,  27'd8849613,  27'd9776460,
      27'd10875817, 27'd12867450, 27'd14131232, 27'd15385821,
      27'd16551013, 27'd17822844, 27'd19897414, 27'd24516315,
      27'd27569192, 27'd37675491, 27'd45046299, 27'd52009352,
      27'd63382721, 27'd73839761, 27'd93962149, 27'd114005312
    }
  };

  function automatic logic [MASS_W-1:0] bp_fix(input logic [IDX_W-1:0] i);
    return MASS_W'(BP_MASS[i]) << FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

// File: sv/plyi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plyi_in_if
// Input channel: one stellar mass per transfer.
// ----------------------------------------------------------------------------
interface plyi_in_if import plyi_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] star_mass;

  modport source (output valid, output star_mass, input ready);
  modport sink   (input valid, input star_mass, output ready);
endinterface
`default_nettype wire

// File: sv/plyi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plyi_out_if
// Output channel: three yields per transfer.
// ----------------------------------------------------------------------------
interface plyi_out_if import plyi_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [TOT_W-1:0] ejecta_total;
  logic [MET_W-1:0]        ejecta_metals;
  logic [WND_W-1:0]        wind_total;

  modport source (output valid, output ejecta_total, output ejecta_metals,
                  output wind_total, input ready);
  modport sink   (input valid, input ejecta_total, input ejecta_metals,
                  input wind_total, output ready);
endinterface
`default_nettype wire

// File: sv/plyi_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plyi_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
module plyi_divider import plyi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][N_W-1:0]  num,
  input  logic [DEN_W-1:0]           den,
  input  side_t                      side_in,
  output logic                       out_valid,
  output logic [LANES-1:0][Q_W-1:0]  quo,
  output side_t                      side_out
);

  logic [LANES-1:0][N_W-1:0]  rem_q  [Q_W-1];
  logic [DEN_W-1:0]           den_q  [Q_W-1];
  logic [LANES-1:0][Q_W-1:0]  quo_q  [Q_W];
  side_t                      side_q [Q_W];
  logic [Q_W-1:0]             valid_q;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;

    logic [LANES-1:0][N_W-1:0] r_in;
    logic [LANES-1:0][Q_W-1:0] q_in;
    logic [LANES-1:0][N_W-1:0] r_next;
    logic [LANES-1:0][Q_W-1:0] q_next;
    logic [DEN_W-1:0]          d_in;
    side_t                     sd_in;
    logic                      v_in;
    logic [N_W-1:0]            shifted;

    if (s == 0) begin : g_src
      assign r_in  = num;
      assign q_in  = '0;
      assign d_in  = den;
      assign sd_in = side_in;
      assign v_in  = in_valid;
    end else begin : g_src
      assign r_in  = rem_q[s-1];
      assign q_in  = quo_q[s-1];
      assign d_in  = den_q[s-1];
      assign sd_in = side_q[s-1];
      assign v_in  = valid_q[s-1];
    end

    assign shifted = N_W'(d_in) << B;

    always_comb begin
      r_next = r_in;
      q_next = q_in;
      for (int l = 0; l < LANES; l++) begin
        if (r_in[l] >= shifted) begin
          r_next[l]    = r_in[l] - shifted;
          q_next[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else if (en) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s]  <= q_next;
        side_q[s] <= sd_in;
      end
    end

    if (s < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= r_next;
          den_q[s] <= d_in;
        end
      end
    end
  end

  assign out_valid = valid_q[Q_W-1];
  assign quo       = quo_q[Q_W-1];
  assign side_out  = side_q[Q_W-1];

endmodule
`default_nettype wire

// File: sv/piecewise_linear_yield_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_yield_interpolator
// Interpolates total ejecta, metal ejecta and wind mass from a 32-point
// breakpoint ROM for one stellar mass per transfer, rounded to nearest.
//
//   channel  dir  fields                                      width
//   star     in   star_mass                                   20 (Q10.10)
//   yields   out  ejecta_total, ejecta_metals, wind_total     16s, 14, 17
//
// One transfer per cycle in and out while the skid register is empty; a
// result passes 5 search/lookup/multiply/sum stages, 17 divider stages
// and the output register. Reset clears all valid bits, including the
// output and skid valid flags; data registers are not reset.
// The pipeline advances while the skid register is empty; star.ready drops
// only while the skid register holds a result behind a stalled output.
// ----------------------------------------------------------------------------
module piecewise_linear_yield_interpolator import plyi_pkg::*; (
  input logic        clk,
  input logic        rst,
  plyi_in_if.sink    star,
  plyi_out_if.source yields
);

  logic en;
  logic skid_valid;

  assign en         = !skid_valid;
  assign star.ready = en;

  // Stage 1: input register
  logic              v1;
  logic [MASS_W-1:0] m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= star.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= star.star_mass;
    end
  end

  // Segment search
  logic [IDX_W-1:0] lo1;
  logic             below1;
  logic             above1;
  side_t            side1;

  always_comb begin
    lo1 = '0;
    for (int j = 0; j < TABLE_POINTS; j++) begin
      if (m1 >= bp_fix(IDX_W'(j))) begin
        lo1 = IDX_W'(j);
      end
    end
    below1       = m1 < bp_fix('0);
    above1       = m1 >= bp_fix(IDX_W'(TABLE_POINTS - 1));
    side1.below  = below1;
    side1.bypass = signed'(TOT_W'(m1) - TOT_W'(BYPASS_OFFSET));
  end

  // Stage 2: segment registers
  logic              v2;
  logic [IDX_W-1:0]  lo2;
  logic              below2;
  logic              above2;
  logic [MASS_W-1:0] m2;
  side_t             side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo2    <= lo1;
      below2 <= below1;
      above2 <= above1;
      m2     <= m1;
      side2  <= side1;
    end
  end

  // Table lookup
  logic [IDX_W-1:0]                   hi2;
  logic [LANES-1:0][Y_W-1:0]          y0_2;
  logic [LANES-1:0][DY_W-1:0]         dy2;
  logic [DX_W-1:0]                    dx2;
  logic [T_W-1:0]                     t2;
  logic [Y_W-1:0]                     y1_tmp;

  always_comb begin
    hi2    = lo2 + IDX_W'(1);
    y1_tmp = '0;
    for (int l = 0; l < LANES; l++) begin
      y0_2[l] = YIELD_TAB[l][lo2];
      y1_tmp  = YIELD_TAB[l][hi2];
      if (below2) begin
        y0_2[l] = (l == LANE_WIND) ? '0 : YIELD_TAB[l][0];
        y1_tmp  = y0_2[l];
      end else if (above2) begin
        y1_tmp  = y0_2[l];
      end
      dy2[l] = DY_W'(y1_tmp) - DY_W'(y0_2[l]);
    end
    if (below2 || above2) begin
      dx2 = DX_W'(1);
      t2  = '0;
    end else begin
      dx2 = DX_W'(BP_MASS[hi2] - BP_MASS[lo2]);
      t2  = T_W'(m2 - bp_fix(lo2));
    end
  end

  // Stage 3: lookup registers
  logic                              v3;
  logic [LANES-1:0][Y_W-1:0]         y0_3;
  logic [LANES-1:0][DY_W-1:0]        dy3;
  logic [DX_W-1:0]                   dx3;
  logic [T_W-1:0]                    t3;
  side_t                             side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0_3  <= y0_2;
      dy3   <= dy2;
      dx3   <= dx2;
      t3    <= t2;
      side3 <= side2;
    end
  end

  // Products
  logic [LANES-1:0][P1_W-1:0]  p1_3;
  logic [LANES-1:0][P2_W-1:0]  p2_3;
  logic [DEN_W-1:0]            half3;
  logic [DEN_W-1:0]            den3;
  logic signed [P2_W-1:0]      t_ext;

  always_comb begin
    t_ext = P2_W'($signed({1'b0, t3}));
    for (int l = 0; l < LANES; l++) begin
      p1_3[l] = P1_W'(y0_3[l]) * P1_W'(dx3);
      p2_3[l] = P2_W'(P2_W'($signed(dy3[l])) * t_ext);
    end
    half3 = DEN_W'(dx3) * DEN_W'(HALF_MICRO);
    den3  = DEN_W'(dx3) * DEN_W'(MICRO);
  end

  // Stage 4: product registers
  logic                        v4;
  logic [LANES-1:0][P1_W-1:0]  p1_4;
  logic [LANES-1:0][P2_W-1:0]  p2_4;
  logic [DEN_W-1:0]            half4;
  logic [DEN_W-1:0]            den4;
  side_t                       side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_4  <= p1_3;
      p2_4  <= p2_3;
      half4 <= half3;
      den4  <= den3;
      side4 <= side3;
    end
  end

  // Rounded numerator
  logic [LANES-1:0][N_W-1:0] num4;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num4[l] = {p1_4[l], {FRAC_BITS{1'b0}}} + N_W'(half4) + N_W'(p2_4[l]);
    end
  end

  // Stage 5: numerator registers
  logic                       v5;
  logic [LANES-1:0][N_W-1:0]  num5;
  logic [DEN_W-1:0]           den5;
  side_t                      side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5  <= num4;
      den5  <= den4;
      side5 <= side4;
    end
  end

  logic                       dv;
  logic [LANES-1:0][Q_W-1:0]  quo;
  side_t                      dside;

  plyi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .num      (num5),
    .den      (den5),
    .side_in  (side5),
    .out_valid(dv),
    .quo      (quo),
    .side_out (dside)
  );

  // Saturate and select the below-table path
  logic signed [TOT_W-1:0] res_tot;
  logic [MET_W-1:0]        res_met;
  logic [WND_W-1:0]        res_wnd;
  logic                    push;
  logic                    pop;

  always_comb begin
    if (dside.below) begin
      res_tot = dside.bypass;
    end else if (quo[LANE_TOTAL] > Q_W'(TOT_MAX)) begin
      res_tot = TOT_W'(TOT_MAX);
    end else begin
      res_tot = signed'(TOT_W'(quo[LANE_TOTAL]));
    end
    if (quo[LANE_METALS] > Q_W'(MET_MAX)) begin
      res_met = MET_W'(MET_MAX);
    end else begin
      res_met = MET_W'(quo[LANE_METALS]);
    end
    res_wnd = WND_W'(quo[LANE_WIND]);
  end

  assign push = en && dv;

  // Output and skid registers
  logic                    out_valid;
  logic signed [TOT_W-1:0] out_tot;
  logic [MET_W-1:0]        out_met;
  logic [WND_W-1:0]        out_wnd;
  logic signed [TOT_W-1:0] skid_tot;
  logic [MET_W-1:0]        skid_met;
  logic [WND_W-1:0]        skid_wnd;

  assign pop = out_valid && yields.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_tot <= skid_tot;
        out_met <= skid_met;
        out_wnd <= skid_wnd;
      end else begin
        out_tot <= res_tot;
        out_met <= res_met;
        out_wnd <= res_wnd;
      end
    end else if (push) begin
      skid_tot <= res_tot;
      skid_met <= res_met;
      skid_wnd <= res_wnd;
    end
  end

  assign yields.valid         = out_valid;
  assign yields.ejecta_total  = out_tot;
  assign yields.ejecta_metals = out_met;
  assign yields.wind_total    = out_wnd;

endmodule
`default_nettype wire
